// File: design/byte_half_word_memory_macros.svh
// Assertion macros shared by the byte_half_word_memory checkers.
// Each macro samples on i_clk and is off while i_rst_n is low.
`ifndef BYTE_HALF_WORD_MEMORY_MACROS_SVH
`define BYTE_HALF_WORD_MEMORY_MACROS_SVH

// Same-cycle implication.
`define BHWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("byte_half_word_memory: check failed");

// Next-cycle implication.
`define BHWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("byte_half_word_memory: check failed");

`endif

// File: design/bhwm_pkg.sv
// Shared constants for the byte/halfword/word memory: store geometry,
// access size codes and operation codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bhwm_pkg;

    // Store size in bytes; a power of two.
    localparam int MEM_BYTES = 65536;
    localparam int WORDS     = MEM_BYTES / 4;
    localparam int BA_W      = $clog2(MEM_BYTES);
    localparam int WORD_W    = BA_W - 2;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 32;
    // Address bits taken from the port (the rest of a byte address is zero).
    localparam int IA_W      = (BA_W < ADDR_W) ? BA_W : ADDR_W;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

endpackage

`default_nettype wire

// File: design/byte_half_word_memory.sv
// Top level of the little-endian byte/halfword/word memory.
// Depends on bhwm_pkg and bhwm_ram.
`timescale 1ns / 1ps
`default_nettype none

// Little-endian store of MEM_BYTES bytes held as 32-bit words in one RAM
// with a registered read. Each item is one read or write of a byte,
// halfword or word; narrow writes merge into their lane by read-modify-write
// and reads come back zero-extended. A word at an address that is not a
// multiple of 4 touches the two words it spans (wrapping at the top of the
// store). A halfword at an odd address uses the lane chosen by address bit 1
// and sets misaligned_half. After reset the block zeroes the RAM one word per
// cycle, all WORDS (16384) words, with o_s_tready low.
// Each item is a RAM read, then compute and write back; an unaligned word
// reads its two words in turn and an unaligned write writes them in turn,
// since both go through the single RAM read port and single write port.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted, and the block stalls only when
// a second result is ready before the first is taken.
module byte_half_word_memory
    import bhwm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // address[15:0], write_data[47:16]
    input  wire logic [2:0]  i_s_tuser,   // op[0], size[2:1]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // read_data[31:0]
    output logic [0:0]       o_m_tuser    // misaligned_half[0]
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_WR1,
        ST_HOLD
    } t_state;

    t_state              r_state, n_state;
    logic [WORD_W-1:0]   r_clr_idx, n_clr_idx;
    logic                r_op, n_op;
    logic [1:0]          r_size, n_size;
    logic [BA_W-1:0]     r_addr, n_addr;
    logic [DATA_W-1:0]   r_wdata, n_wdata;
    logic [DATA_W-1:0]   r_w0, n_w0;
    logic [DATA_W-1:0]   r_w1n, n_w1n;
    logic [DATA_W-1:0]   r_res, n_res;
    logic                r_mis, n_mis;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic                r_out_mis, n_out_mis;

    logic                ram_we;
    logic [WORD_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                s_acc;
    logic                slot_free;
    logic [BA_W-1:0]     in_addr;
    logic [WORD_W-1:0]   idx0, idx1;
    logic [1:0]          lane;
    logic                unaligned;
    logic                mis;
    logic [4:0]          sh8, sh16;
    logic [DATA_W-1:0]   rd_al, merged;
    logic                wr_al;
    logic [63:0]         pair, pair_new;
    logic [DATA_W-1:0]   rd_un;

    bhwm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;
    assign in_addr    = BA_W'(i_s_tdata[IA_W-1:0]);

    assign idx0      = r_addr[BA_W-1:2];
    assign idx1      = idx0 + 1'b1;
    assign lane      = r_addr[1:0];
    assign unaligned = (r_size == SZ_WORD) && (lane != 2'd0);
    assign mis       = (r_size == SZ_HALF) && r_addr[0];
    assign sh8       = {lane, 3'b000};
    assign sh16      = {r_addr[1], 4'b0000};

    // Aligned access: extract and merge within the word just read.
    always_comb begin
        rd_al  = '0;
        merged = ram_rdata;
        wr_al  = 1'b0;
        case (r_size)
            SZ_BYTE: begin
                rd_al  = DATA_W'(8'(ram_rdata >> sh8));
                merged = (ram_rdata & ~(DATA_W'(8'hff) << sh8))
                       | (DATA_W'(r_wdata[7:0]) << sh8);
                wr_al  = 1'b1;
            end
            SZ_HALF: begin
                rd_al  = DATA_W'(16'(ram_rdata >> sh16));
                merged = (ram_rdata & ~(DATA_W'(16'hffff) << sh16))
                       | (DATA_W'(r_wdata[15:0]) << sh16);
                wr_al  = 1'b1;
            end
            SZ_WORD: begin
                rd_al  = ram_rdata;
                merged = r_wdata;
                wr_al  = 1'b1;
            end
            default: begin
                rd_al  = '0;
                merged = ram_rdata;
                wr_al  = 1'b0;
            end
        endcase
    end

    // Unaligned word: the low word is held in r_w0, the high word is on the RAM output.
    always_comb begin
        int k;
        pair     = {ram_rdata, r_w0};
        pair_new = pair;
        for (int j = 0; j < 8; j++) begin
            k = j - int'(lane);
            if (k >= 0 && k < 4) begin
                pair_new[j*8 +: 8] = r_wdata[k*8 +: 8];
            end
        end
        rd_un = DATA_W'(pair >> sh8);
    end

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx0;
        ram_wdata = merged;
        ram_raddr = idx0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                ram_raddr = in_addr[BA_W-1:2];
            end
            ST_RD0: begin
                ram_raddr = idx1;
                ram_we    = (r_op == OP_WRITE) && wr_al && !unaligned;
            end
            ST_RD1: begin
                ram_we    = (r_op == OP_WRITE);
                ram_wdata = pair_new[31:0];
            end
            ST_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = idx1;
                ram_wdata = r_w1n;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_op        = r_op;
        n_size      = r_size;
        n_addr      = r_addr;
        n_wdata     = r_wdata;
        n_w0        = r_w0;
        n_w1n       = r_w1n;
        n_res       = r_res;
        n_mis       = r_mis;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_mis   = r_out_mis;
        case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == WORD_W'(WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    n_op    = i_s_tuser[0];
                    n_size  = i_s_tuser[2:1];
                    n_addr  = in_addr;
                    n_wdata = i_s_tdata[47:16];
                    n_state = ST_RD0;
                end
            end
            ST_RD0: begin
                n_w0 = ram_rdata;
                if (unaligned) begin
                    n_state = ST_RD1;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_op == OP_WRITE) ? '0 : rd_al;
                    n_out_mis   = mis;
                    n_state     = ST_IDLE;
                end else begin
                    n_res   = (r_op == OP_WRITE) ? '0 : rd_al;
                    n_mis   = mis;
                    n_state = ST_HOLD;
                end
            end
            ST_RD1: begin
                n_w1n = pair_new[63:32];
                n_res = (r_op == OP_WRITE) ? '0 : rd_un;
                n_mis = 1'b0;
                if (r_op == OP_WRITE) begin
                    n_state = ST_WR1;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = rd_un;
                    n_out_mis   = 1'b0;
                    n_state     = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_WR1, ST_HOLD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_out_mis   = r_mis;
                    n_state     = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_size     <= n_size;
        r_addr     <= n_addr;
        r_wdata    <= n_wdata;
        r_w0       <= n_w0;
        r_w1n      <= n_w1n;
        r_res      <= n_res;
        r_mis      <= n_mis;
        r_out_data <= n_out_data;
        r_out_mis  <= n_out_mis;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_mis;

endmodule

`default_nettype wire

// File: design/bhwm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bhwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/bhwm_checker.sv
// Port-level checks for byte_half_word_memory, attached by bind.
// Depends on byte_half_word_memory_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_half_word_memory_macros.svh"

module bhwm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic [0:0]  o_m_tuser
);

    // One item in work at a time: ready drops right after an accept.
    `BHWM_ASSERT_NEXT(a_one_in_work, i_s_tvalid && o_s_tready, !o_s_tready)

    // The clearing pass keeps the input closed when reset releases.
    `BHWM_ASSERT_NOW(a_clear_after_reset, $rose(i_rst_n), !o_s_tready)

    // A misaligned flag only comes with a halfword result, zero-extended.
    `BHWM_ASSERT_NOW(a_half_zero_ext, o_m_tvalid && o_m_tuser[0], o_m_tdata[31:16] == 16'h0000)

    // A stalled result holds.
    `BHWM_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

endmodule

bind byte_half_word_memory bhwm_checker u_bhwm_checker (.*);

`default_nettype wire
